FILE: hdl/slmap_pkg.sv
// Shared types and constants for the sorted leaf map lookup/insert unit.
// No dependencies.
`timescale 1ns / 1ps

package slmap_pkg;

  localparam int KEY_W       = 64;
  localparam int VAL_W       = 64;
  localparam int ENTRIES_DEF = 64;

  typedef logic [1:0]       status_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [VAL_W-1:0] val_t;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_NOT_FOUND = 2'd1;
  localparam status_t ST_FULL      = 2'd2;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

endpackage

FILE: hdl/slmap_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module slmap_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/sorted_leaf_map_lookup_insert_unit.sv
// Top level of the sorted leaf map lookup/insert unit.
// Depends on slmap_pkg and slmap_ram (key and value tables).
`timescale 1ns / 1ps

// One B-tree leaf held as a key-sorted table of up to ENTRIES key/value
// pairs in two RAMs (keys, values) sharing one address sequencer. A word with
// cmd=0 looks up lookup_key: the table is scanned from entry 0, the first
// equal key answers status ok with its value, a greater key or the end of
// the table answers not found with found_value zero. A word with cmd=1
// inserts lookup_key/new_value before the first entry whose key is not less
// than it (so among equal keys the newest comes first), or answers table
// full and leaves the table untouched. Keys compare as unsigned 64-bit
// numbers. Every input word yields exactly one result word. One word is
// worked on at a time: the scan reads and then compares each entry visited,
// and an insert then shifts each entry above the slot up (read, then write),
// top first, and finally writes the new pair. The next word is taken while a
// finished result still waits on out_stall. No clearing pass is needed after
// reset: entries at or above the count are never read.
module sorted_leaf_map_lookup_insert_unit
  import slmap_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  // input channel
  input  logic    in_valid,
  output logic    in_stall,
  input  logic    cmd,
  input  key_t    lookup_key,
  input  val_t    new_value,
  // result channel
  output logic    out_valid,
  input  logic    out_stall,
  output status_t status,
  output val_t    found_value
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RD     = 3'd1;  // read entry idx
  localparam logic [2:0] S_CMP    = 3'd2;  // compare entry idx
  localparam logic [2:0] S_SH_RD  = 3'd3;  // read entry idx-1
  localparam logic [2:0] S_SH_WR  = 3'd4;  // write it to entry idx
  localparam logic [2:0] S_INS_WR = 3'd5;  // write new pair at pos
  localparam logic [2:0] S_DONE   = 3'd6;  // hand result to output reg

  logic [2:0]    state;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic [CW-1:0] count;
  logic          cmd_q;
  key_t          key_q;
  val_t          val_q;
  status_t       res_status;
  val_t          res_value;

  // RAM ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  key_t          key_wdata;
  val_t          val_wdata;
  key_t          key_rdata;
  val_t          val_rdata;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          full;

  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);
  assign full    = (count == CW'(ENTRIES));

  // New words only while the sequencer is free; the output register decouples
  // the result side.
  assign in_stall = (state != S_IDLE);

  always_comb begin
    we        = 1'b0;
    waddr     = idx[AW-1:0];
    key_wdata = key_rdata;
    val_wdata = val_rdata;
    raddr     = idx[AW-1:0];
    unique case (state)
      S_SH_RD: begin
        raddr = idx_dec[AW-1:0];
      end
      S_SH_WR: begin
        we = 1'b1;
      end
      S_INS_WR: begin
        we        = 1'b1;
        waddr     = pos[AW-1:0];
        key_wdata = key_q;
        val_wdata = val_q;
      end
      default: begin
      end
    endcase
  end

  slmap_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key_wdata),
    .raddr (raddr),
    .rdata (key_rdata)
  );

  slmap_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (val_wdata),
    .raddr (raddr),
    .rdata (val_rdata)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_q <= cmd;
            key_q <= lookup_key;
            val_q <= new_value;
            idx   <= '0;
            if (cmd == CMD_INSERT && full) begin
              res_status <= ST_FULL;
              res_value  <= '0;
              state      <= S_DONE;
            end else if (count == '0) begin
              if (cmd == CMD_INSERT) begin
                pos   <= '0;
                state <= S_INS_WR;
              end else begin
                res_status <= ST_NOT_FOUND;
                res_value  <= '0;
                state      <= S_DONE;
              end
            end else begin
              state <= S_RD;
            end
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (cmd_q == CMD_LOOKUP) begin
            if (key_rdata == key_q) begin
              res_status <= ST_OK;
              res_value  <= val_rdata;
              state      <= S_DONE;
            end else if (key_rdata > key_q || idx_inc == count) begin
              // early stop on a greater key, or end of table
              res_status <= ST_NOT_FOUND;
              res_value  <= '0;
              state      <= S_DONE;
            end else begin
              idx   <= idx_inc;
              state <= S_RD;
            end
          end else begin
            if (key_rdata >= key_q) begin
              // slot found; shift entries pos..count-1 up, top first
              pos   <= idx;
              idx   <= count;
              state <= S_SH_RD;
            end else if (idx_inc == count) begin
              pos   <= count;
              state <= S_INS_WR;
            end else begin
              idx   <= idx_inc;
              state <= S_RD;
            end
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          idx <= idx_dec;
          if (idx_dec == pos) begin
            state <= S_INS_WR;
          end else begin
            state <= S_SH_RD;
          end
        end
        S_INS_WR: begin
          count      <= count + CW'(1);
          res_status <= ST_OK;
          res_value  <= '0;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || !out_stall)) begin
      status      <= res_status;
      found_value <= res_value;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("entry count above capacity");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (rst)
    (state == S_SH_WR) |-> (idx > pos))
    else $error("shift write at or below insert slot");

  a_insert_bumps_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS_WR) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not raise entry count");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result word raised outside completion");

  a_full_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> full)
    else $error("table full reported while slots free");
`endif

endmodule
